// File: rtl/core/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants for the frame allocator
// Command codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bfa_pkg;

	localparam int CountW = 17;
	localparam logic [CountW-1:0] CountMax = '1;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_RESERVE = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_RD,
		ST_WAIT,
		ST_EVAL,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_step;   // write all-ones at clear pointer, advance
		logic load;       // capture command
		logic setup;      // compute frame range
		logic rd;         // issue map read at current word/frame
		logic eval;       // evaluate read word, write back, advance
		logic done;       // present result
	} dp_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;   // last word of clearing pass
		logic finished;   // command has nothing more to do
	} dp_sts_t;

endpackage

// File: rtl/core/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl: sequencer for the frame allocator
// Runs the clearing pass after reset, then one command at a time.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output dp_ctl_t ctl,
	input  dp_sts_t sts
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_RD;
			ST_RD:    state_d = sts.finished ? ST_DONE : ST_WAIT;
			ST_WAIT:  state_d = ST_EVAL;
			ST_EVAL:  state_d = sts.finished ? ST_DONE : ST_RD;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: ctl.clr_step = 1'b1;
			ST_IDLE: begin
				busy = 1'b0;
				ctl.load = start;
			end
			ST_SETUP: ctl.setup = 1'b1;
			ST_RD:    ctl.rd = !sts.finished;
			ST_WAIT:  ;
			ST_EVAL:  ctl.eval = 1'b1;
			ST_DONE:  ctl.done = 1'b1;
			default:  ;
		endcase
	end

endmodule

// File: rtl/core/bfa_dp.sv
// ----------------------------------------------------------------------------
// bfa_dp: map memory, counters and range walker
// Works one map word per read/eval pair; range commands use a bit mask
// per word so a whole word of frames is handled in one step.
// ----------------------------------------------------------------------------
module bfa_dp import bfa_pkg::*; #(
	parameter int NUM_FRAMES = 65536,
	parameter int PAGE_SHIFT = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_ctl_t           ctl,
	output dp_sts_t           sts,
	input  logic [10:0]       scan_start_word,
	input  logic [1:0]        cmd,
	input  logic [31:0]       byte_addr,
	input  logic [31:0]       byte_len,
	output logic              done,
	output logic [31:0]       frame_addr,
	output logic              status,
	output logic [CountW-1:0] free_count,
	output logic [CountW-1:0] total_count
);

	localparam int MapWords = NUM_FRAMES / 32;
	localparam int WW = $clog2(MapWords);
	localparam int FW = 32 - PAGE_SHIFT;   // frame number width from an address
	localparam int FrameSpan = 1 << FW;    // frames a 32-bit address can reach
	localparam int FrameLim = (NUM_FRAMES < FrameSpan) ? NUM_FRAMES : FrameSpan;

	logic [31:0] mem [MapWords];
	logic [31:0] rdata_q;

	logic [WW:0]         clr_ptr_q;
	cmd_t                cmd_q;
	logic [31:0]         addr_q, len_q;
	logic [FW:0]         f_q, fend_q;     // current frame, end frame (exclusive)
	logic [WW:0]         word_q;
	logic                fin_q, ok_q;
	logic [31:0]         got_q;
	logic [CountW-1:0]   free_q, total_q;
	logic                done_q;

	// range setup
	logic [31:0] page_m1, sum_al, base_up, end_up, end_ex;
	assign page_m1 = (32'd1 << PAGE_SHIFT) - 32'd1;
	assign sum_al  = addr_q + len_q;
	assign end_up  = sum_al + page_m1;
	assign base_up = addr_q + page_m1;
	assign end_ex  = sum_al;

	logic [FW:0] f_first, f_last, f_lim;
	always_comb begin
		f_lim = (FW+1)'(FrameLim);
		if (cmd_q == CMD_RESERVE) begin
			f_first = {1'b0, addr_q[31:PAGE_SHIFT]};
			f_last  = {1'b0, end_up[31:PAGE_SHIFT]};
		end else begin
			f_first = {1'b0, base_up[31:PAGE_SHIFT]};
			f_last  = {1'b0, end_ex[31:PAGE_SHIFT]};
		end
		if (f_last > f_lim) f_last = f_lim;
	end

	// word-level masks of frames in [f_q, fend_q) for current word
	logic [WW:0] cur_word;
	logic [31:0] lo_mask, hi_mask, rng_mask, hit, new_word;
	logic [FW:0] word_base, word_next;
	logic [5:0]  hit_cnt;
	logic [4:0]  first_free;
	logic        any_free;
	always_comb begin
		cur_word  = (cmd_q == CMD_ALLOC) ? word_q : (WW+1)'(f_q >> 5);
		word_base = (FW+1)'(cur_word) << 5;
		word_next = word_base + (FW+1)'(32);
		lo_mask   = 32'hFFFF_FFFF << f_q[4:0];
		if (fend_q >= word_next) hi_mask = 32'hFFFF_FFFF;
		else hi_mask = ~(32'hFFFF_FFFF << fend_q[4:0]);
		rng_mask  = lo_mask & hi_mask;
		if (cmd_q == CMD_FREE) rng_mask = 32'd1 << f_q[4:0];
		if (cmd_q == CMD_RESERVE) hit = rng_mask & ~rdata_q;
		else hit = rng_mask & rdata_q;
		hit_cnt = '0;
		for (int i = 0; i < 32; i++) hit_cnt = hit_cnt + 6'(hit[i]);
		any_free = ~&rdata_q;
		first_free = '0;
		for (int i = 31; i >= 0; i--) if (!rdata_q[i]) first_free = 5'(i);
		case (cmd_q)
			CMD_ALLOC:   new_word = rdata_q | (32'd1 << first_free);
			CMD_RESERVE: new_word = rdata_q | rng_mask;
			default:     new_word = rdata_q & ~rng_mask;
		endcase
	end

	function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] a,
		input logic [5:0] b);
		logic [CountW:0] s;
		s = {1'b0, a} + (CountW+1)'(b);
		return s > (CountW+1)'(CountMax) ? CountMax : s[CountW-1:0];
	endfunction

	function automatic logic [CountW-1:0] sat_sub(input logic [CountW-1:0] a,
		input logic [5:0] b);
		return a > CountW'(b) ? a - CountW'(b) : '0;
	endfunction

	// memory
	always_ff @(posedge clk) begin
		if (ctl.clr_step) mem[clr_ptr_q[WW-1:0]] <= 32'hFFFF_FFFF;
		else if (ctl.eval && !fin_q &&
			((cmd_q == CMD_ALLOC && any_free) || (cmd_q != CMD_ALLOC && hit != '0)))
			mem[cur_word[WW-1:0]] <= new_word;
		if (ctl.rd) rdata_q <= mem[cur_word[WW-1:0]];
	end

	logic [31:0] alloc_addr;
	logic [FW+WW+5:0] alloc_f;
	assign alloc_f = (FW+WW+6)'({word_q[WW-1:0], first_free});
	assign alloc_addr = 32'((64'(alloc_f)) << PAGE_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q <= '0;
			free_q    <= '0;
			total_q   <= '0;
			fin_q     <= 1'b0;
			done_q    <= 1'b0;
			cmd_q     <= CMD_ALLOC;
			addr_q    <= '0;
			len_q     <= '0;
			ok_q      <= 1'b0;
			got_q     <= '0;
			word_q    <= '0;
			f_q       <= '0;
			fend_q    <= '0;
		end else begin
			done_q <= ctl.done;
			if (ctl.clr_step) clr_ptr_q <= clr_ptr_q + 1'b1;
			if (ctl.load) begin
				cmd_q  <= cmd_t'(cmd);
				addr_q <= byte_addr;
				len_q  <= byte_len;
				ok_q   <= 1'b0;
				got_q  <= '0;
				word_q <= (WW+1)'(scan_start_word);
				fin_q  <= 1'b0;
			end
			if (ctl.setup) begin
				case (cmd_q)
					CMD_ALLOC: begin
						fin_q <= (free_q == '0) ||
							((WW+1)'(scan_start_word) >= (WW+1)'(MapWords)) ||
							(scan_start_word > 11'(MapWords - 1));
					end
					CMD_FREE: begin
						f_q    <= {1'b0, addr_q[31:PAGE_SHIFT]};
						fend_q <= {1'b0, addr_q[31:PAGE_SHIFT]} + (FW+1)'(1);
						fin_q  <= {1'b0, addr_q[31:PAGE_SHIFT]} >= (FW+1)'(FrameLim);
					end
					default: begin
						f_q    <= f_first;
						fend_q <= f_last;
						fin_q  <= f_first >= f_last;
					end
				endcase
			end
			if (ctl.eval) begin
				if (cmd_q == CMD_ALLOC) begin
					if (any_free) begin
						got_q  <= alloc_addr;
						ok_q   <= 1'b1;
						free_q <= free_q - 1'b1;
						fin_q  <= 1'b1;
					end else begin
						word_q <= word_q + 1'b1;
						fin_q  <= (word_q + 1'b1) >= (WW+1)'(MapWords);
					end
				end else begin
					if (hit != '0) ok_q <= 1'b1;
					case (cmd_q)
						CMD_RESERVE: free_q <= sat_sub(free_q, hit_cnt);
						CMD_RELEASE: begin
							free_q  <= sat_add(free_q, hit_cnt);
							total_q <= sat_add(total_q, hit_cnt);
						end
						default: free_q <= sat_add(free_q, hit_cnt);
					endcase
					f_q   <= word_next;
					fin_q <= (cmd_q == CMD_FREE) || (word_next >= fend_q);
				end
			end
		end
	end

	assign sts.clr_last = clr_ptr_q == (WW+1)'(MapWords - 1);
	assign sts.finished = fin_q;
	assign done        = done_q;
	assign frame_addr  = got_q;
	assign status      = !ok_q;
	assign free_count  = free_q;
	assign total_count = total_q;

endmodule

// File: rtl/core/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator: bitmap page-frame allocator
// One bit per frame (1 = used), with free and total frame counters.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd, byte_addr, byte_len with start high; the
//   transfer happens on a clock edge where start is high and busy is low.
//   busy stays high until the cycle in which the result is shown.
//   Commands: allocate, free one frame, reserve range, release range.
//   Result channel: done pulses for one cycle with frame_addr, status,
//   free_count and total_count. The receiver cannot stall; sample on done.
//   Config: scan_start_word is written via cfg_valid/cfg_ready; cfg_ready
//   is high only while busy is low and no command is being presented.
// Sequence: setup, then read, wait and evaluate per map word visited,
//   then done; the map memory's single read port and read/modify/write
//   per word set this. Allocate walks map words from scan_start_word
//   until one has a free bit or the map ends; range commands visit every
//   word the range touches, 32 frames per step. Free touches one word.
// Throughput: one command at a time; the next transfer can happen in the
//   cycle that shows the previous result.
// Reset: the map is filled with all-ones by a clearing pass over all
//   NUM_FRAMES/32 map words, one word per cycle, during which busy is high.
//   Counts reset to zero and scan_start_word to 8.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator import bfa_pkg::*; #(
	parameter int NUM_FRAMES = 65536,
	parameter int PAGE_SHIFT = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        cmd,
	input  logic [31:0]       byte_addr,
	input  logic [31:0]       byte_len,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [10:0]       cfg_data,
	output logic              done,
	output logic [31:0]       frame_addr,
	output logic              status,
	output logic [CountW-1:0] free_count,
	output logic [CountW-1:0] total_count
);

	dp_ctl_t ctl;
	dp_sts_t sts;
	logic [10:0] start_word_q;

	// config register; only taken between commands
	assign cfg_ready = !busy && !start;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_word_q <= 11'd8;
		else if (cfg_valid && cfg_ready) start_word_q <= cfg_data;
	end

	bfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl),
		.sts    (sts)
	);

	bfa_dp #(
		.NUM_FRAMES (NUM_FRAMES),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.scan_start_word (start_word_q),
		.cmd             (cmd),
		.byte_addr       (byte_addr),
		.byte_len        (byte_len),
		.done            (done),
		.frame_addr      (frame_addr),
		.status          (status),
		.free_count      (free_count),
		.total_count     (total_count)
	);

endmodule
